FILE: hw/rtl/ps2sa_pkg.sv
// ps2sa_pkg: shared constants, types and the continuation rule
// for the ps/2 scan code set 2 sequence assembler. no dependencies.

package ps2sa_pkg;

  localparam int BYTE_W      = 8;
  localparam int STORE_DEPTH = 8;
  localparam int CODE_W      = BYTE_W * STORE_DEPTH;
  localparam int LEN_W       = 4;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam int MAX_SEQUENCE_BYTES_DEF = 8;

  localparam logic [CFG_ADDR_W-1:0] ADDR_SUPPRESS = 3'd0;

  localparam logic [BYTE_W-1:0] CODE_ACK    = 8'hFA;
  localparam logic [BYTE_W-1:0] CODE_RESEND = 8'hFE;
  localparam logic [BYTE_W-1:0] CODE_EXT0   = 8'hE0;
  localparam logic [BYTE_W-1:0] CODE_BREAK  = 8'hF0;
  localparam logic [BYTE_W-1:0] CODE_EXT1   = 8'hE1;
  localparam logic [BYTE_W-1:0] CODE_LSHIFT = 8'h12;
  localparam logic [BYTE_W-1:0] CODE_LCTRL  = 8'h14;
  localparam logic [BYTE_W-1:0] CODE_NUMLK  = 8'h77;
  localparam logic [BYTE_W-1:0] CODE_KPMUL  = 8'h7C;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // n: bytes held after the append, b_new: byte just appended, b_first: first byte
  function automatic logic more_follow(input logic [LEN_W-1:0] n,
                                       input logic [BYTE_W-1:0] b_new,
                                       input logic [BYTE_W-1:0] b_first);
    logic r;
    r = 1'b0;
    unique case (n)
      4'd1: r = (b_new == CODE_EXT0) || (b_new == CODE_BREAK) || (b_new == CODE_EXT1);
      4'd2: r = (b_new == CODE_BREAK) ||
                ((b_first == CODE_EXT0) && (b_new == CODE_LSHIFT)) ||
                ((b_first == CODE_EXT1) && (b_new == CODE_LCTRL));
      4'd3: r = (b_new == CODE_NUMLK) || (b_new == CODE_KPMUL) || (b_new == CODE_EXT0);
      4'd4: r = (b_new == CODE_EXT0) || (b_new == CODE_EXT1);
      4'd5: r = (b_new == CODE_BREAK);
      4'd6: r = (b_new == CODE_LCTRL);
      4'd7: r = (b_new == CODE_BREAK);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/ps2sa_cell.sv
// ps2sa_cell: one byte stage of the sequence shift chain.
// depends on ps2sa_pkg.

module ps2sa_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ps2sa_pkg::cell_ctrl_t        ctrl,
  input  logic [ps2sa_pkg::BYTE_W-1:0] d_in,
  output logic [ps2sa_pkg::BYTE_W-1:0] q
);
  import ps2sa_pkg::*;

  logic [BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= d_in;
    end
  end

  assign q = held;

endmodule

FILE: hw/rtl/ps2sa_top_dummy_guard.sv
// ps2sa_cnt: byte counter of the sequence assembler with its bound check.
// depends on ps2sa_pkg.

module ps2sa_cnt #(
  parameter int MAX_SEQUENCE_BYTES = ps2sa_pkg::MAX_SEQUENCE_BYTES_DEF,
  parameter int CNT_W              = $clog2(MAX_SEQUENCE_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [CNT_W-1:0] count_next,
  output logic [CNT_W-1:0] count,
  output logic             full
);
  import ps2sa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= count_next;
    end
  end

  assign full = (count >= CNT_W'(MAX_SEQUENCE_BYTES));

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CNT_W'(MAX_SEQUENCE_BYTES);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("byte count past limit");

  property p_count_hold;
    @(posedge clk) disable iff (rst) !load |=> $stable(count);
  endproperty
  a_count_hold: assert property (p_count_hold) else $error("count moved without a load");

  property p_full_reset;
    @(posedge clk) disable iff (rst) (load && full && count_next != '0) |-> 1'b0;
  endproperty
  a_full_reset: assert property (p_full_reset) else $error("full store did not restart");

endmodule

FILE: hw/rtl/ps2_scancode_assembler_top.sv
// ps2_scancode_assembler_top: ps/2 scan code set 2 sequence assembler.
// depends on ps2sa_pkg, ps2sa_cell, ps2sa_cnt.
//
// Takes one keyboard byte per beat and gathers scan code set 2 sequences in
// a chain of byte cells; a finished sequence leaves as one beat holding the
// bytes packed big-endian (last byte in bits 7..0) and its length. One byte
// is taken every cycle while the output register can take a beat: the whole
// decision is a compare of the new byte and the first stored byte against a
// few fixed codes, and the result lands in an output register that takes a
// new beat whenever it is empty or being drained in the same cycle.
// Acknowledge and resend bytes, and all bytes while suppress is set, are
// dropped; a byte arriving with the store full is dropped and the store restarts.

module ps2_scancode_assembler_top #(
  parameter int MAX_SEQUENCE_BYTES = ps2sa_pkg::MAX_SEQUENCE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ps2sa_pkg::BYTE_W-1:0]     s_tdata,   // scan_byte[7:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ps2sa_pkg::OUT_DATA_W-1:0] m_tdata,   // full_code[63:0], code_length[67:64]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ps2sa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ps2sa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ps2sa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import ps2sa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEQUENCE_BYTES + 1);

  logic                suppress;
  logic [BYTE_W-1:0]   tap [MAX_SEQUENCE_BYTES+1];
  cell_ctrl_t          cctl;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    n_new;
  logic                full;
  logic                in_fire;
  logic                drop;
  logic                more;
  logic                done;
  logic [CODE_W-1:0]   code_next;
  logic [CODE_W-1:0]   full_code;
  logic [LEN_W-1:0]    code_length;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      suppress <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SUPPRESS) begin
      suppress <= pwdata[0];
    end
  end
  assign prdata = (paddr == ADDR_SUPPRESS) ? {{(CFG_DATA_W-1){1'b0}}, suppress} : '0;

  // cell chain
  assign tap[0] = s_tdata;
  for (genvar i = 0; i < MAX_SEQUENCE_BYTES; i++) begin : g_cell
    ps2sa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cctl),
      .d_in (tap[i]),
      .q    (tap[i+1])
    );
  end

  ps2sa_cnt #(
    .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES),
    .CNT_W              (CNT_W)
  ) u_cnt (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire && !drop),
    .count_next (count_next),
    .count      (count),
    .full       (full)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign drop     = suppress || (s_tdata == CODE_ACK) || (s_tdata == CODE_RESEND);
  assign n_new    = count + CNT_W'(1);
  assign more     = more_follow(LEN_W'(n_new), s_tdata, tap[1]);
  assign done     = in_fire && !drop && !full && !more;

  always_comb begin
    cctl.shift = in_fire && !drop && !full;
    cctl.clear = in_fire && !drop && (full || !more);
    count_next = (full || !more) ? '0 : n_new;
  end

  always_comb begin
    code_next = '0;
    for (int i = 0; i < MAX_SEQUENCE_BYTES; i++) begin
      code_next[i*BYTE_W +: BYTE_W] = tap[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      full_code   <= code_next;
      code_length <= LEN_W'(n_new);
    end
  end

  assign m_tdata = {{(OUT_DATA_W-CODE_W-LEN_W){1'b0}}, code_length, full_code};

  property p_len_range;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> (code_length != '0 && code_length <= LEN_W'(MAX_SEQUENCE_BYTES));
  endproperty
  a_len_range: assert property (p_len_range) else $error("result length out of range");

  property p_done_clears;
    @(posedge clk) disable iff (rst) done |=> (count == '0 && tap[1] == '0);
  endproperty
  a_done_clears: assert property (p_done_clears) else $error("store not cleared after result");

  property p_stall_blocks;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |-> !in_fire;
  endproperty
  a_stall_blocks: assert property (p_stall_blocks) else $error("byte taken over a held result");

endmodule
